@@ rtl/tun_pkg.sv @@
// Package: shared constants for the triangle unit normal block.
`timescale 1ns / 1ps

package tun_pkg;

  // Default coordinate width (two's complement)
  localparam int unsigned COORD_BITS_DEF = 16;
  // Default fraction bits of the Q1.F unit normal components
  localparam int unsigned NFRAC_BITS_DEF = 15;
  // Vector lanes: x, y, z
  localparam int unsigned NUM_LANES      = 3;

endpackage

@@ rtl/tun_if.sv @@
// Interfaces: triangle input channel and unit normal output channel.
`timescale 1ns / 1ps

interface tun_in_if import tun_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;
  logic                         last_face;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z, last_face,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z, last_face,
    output ready
  );
endinterface

interface tun_out_if import tun_pkg::*; #(
  parameter int unsigned NORMAL_FRAC_BITS = NFRAC_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic signed [NORMAL_FRAC_BITS:0]    normal_x;
  logic signed [NORMAL_FRAC_BITS:0]    normal_y;
  logic signed [NORMAL_FRAC_BITS:0]    normal_z;
  logic                                degenerate;
  logic                                last_out;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate, last_out,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate, last_out,
    output ready
  );
endinterface

@@ rtl/triangle_unit_normal.sv @@
// Top level: pipelined unit face normal of a triangle (cross product / length).
//
//  channel | dir | payload                                         | handshake
//  in_i    | in  | first/second/third x,y,z (COORD_BITS), last_face | valid/ready
//  out_o   | out | normal_x/y/z (Q1.F), degenerate, last_out       | valid/ready
//
// One triangle per cycle while the output is not stalled; the stages are:
// edges, products, cross, split squares, assembled squares, square sum with search seed,
// then one stage per result bit of the square-root-free rounding search, then the
// output register.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
// A result held at the output with ready low freezes every stage together, so
// in_i.ready drops in that cycle; the whole pipe holds, bubbles included.
`timescale 1ns / 1ps

module triangle_unit_normal import tun_pkg::*; #(
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = NFRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    in_i,
  tun_out_if.source out_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned EW  = CB + 1;          // edge width
  localparam int unsigned PRW = 2 * CB + 1;      // edge product width
  localparam int unsigned CW  = 2 * CB + 2;      // cross component, signed
  localparam int unsigned MW  = 2 * CB + 1;      // cross magnitude
  localparam int unsigned LW  = MW / 2;          // low half of magnitude
  localparam int unsigned HW  = MW - LW;         // high half of magnitude
  localparam int unsigned QW  = 2 * MW;          // square width
  localparam int unsigned SW  = QW + 2;          // sum of squares
  localparam int unsigned RW  = SW + 2 * F + 6;  // search remainder, signed
  localparam int unsigned NW  = F + 1;           // result width
  localparam int unsigned NS  = F + 1;           // search stages

  // Whole pipe moves when the output register is free or being drained
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---------------- stage 1: edges ----------------
  logic                 v1_q, l1_q;
  logic signed [EW-1:0] a_q [NUM_LANES];
  logic signed [EW-1:0] b_q [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q   <= in_i.last_face;
      a_q[0] <= EW'(in_i.second_x) - EW'(in_i.first_x);
      a_q[1] <= EW'(in_i.second_y) - EW'(in_i.first_y);
      a_q[2] <= EW'(in_i.second_z) - EW'(in_i.first_z);
      b_q[0] <= EW'(in_i.third_x) - EW'(in_i.first_x);
      b_q[1] <= EW'(in_i.third_y) - EW'(in_i.first_y);
      b_q[2] <= EW'(in_i.third_z) - EW'(in_i.first_z);
    end
  end

  // ---------------- stage 2: edge products ----------------
  logic                  v2_q, l2_q;
  logic signed [PRW-1:0] pp_q [NUM_LANES];   // first term of each component
  logic signed [PRW-1:0] pm_q [NUM_LANES];   // subtracted term

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l2_q    <= l1_q;
      pp_q[0] <= PRW'(a_q[1]) * PRW'(b_q[2]);
      pm_q[0] <= PRW'(a_q[2]) * PRW'(b_q[1]);
      pp_q[1] <= PRW'(a_q[2]) * PRW'(b_q[0]);
      pm_q[1] <= PRW'(a_q[0]) * PRW'(b_q[2]);
      pp_q[2] <= PRW'(a_q[0]) * PRW'(b_q[1]);
      pm_q[2] <= PRW'(a_q[1]) * PRW'(b_q[0]);
    end
  end

  // ---------------- stage 3: cross product as sign and magnitude ----------------
  logic          v3_q, l3_q;
  logic [MW-1:0] mag3_q [NUM_LANES];
  logic          neg3_q [NUM_LANES];
  logic signed [CW-1:0] cross_d [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_cross
    assign cross_d[l] = CW'(pp_q[l]) - CW'(pm_q[l]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg3_q[l] <= cross_d[l][CW-1];
        mag3_q[l] <= cross_d[l][CW-1] ? MW'(-cross_d[l]) : MW'(cross_d[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l3_q <= l2_q;
    end
  end

  // ---------------- stage 4: squares as split partial products ----------------
  logic               v4_q, l4_q;
  logic [2*HW-1:0]    hh_q  [NUM_LANES];
  logic [HW+LW-1:0]   hl_q  [NUM_LANES];
  logic [2*LW-1:0]    ll_q  [NUM_LANES];
  logic [MW-1:0]      mag4_q[NUM_LANES];
  logic               neg4_q[NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_part
    logic [HW-1:0] hi;
    logic [LW-1:0] lo;
    assign hi = mag3_q[l][MW-1:LW];
    assign lo = mag3_q[l][LW-1:0];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hh_q[l]   <= (2*HW)'(hi) * (2*HW)'(hi);
        hl_q[l]   <= (HW+LW)'(hi) * (HW+LW)'(lo);
        ll_q[l]   <= (2*LW)'(lo) * (2*LW)'(lo);
        mag4_q[l] <= mag3_q[l];
        neg4_q[l] <= neg3_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l4_q <= l3_q;
    end
  end

  // ---------------- stage 5: assemble squares ----------------
  logic          v5_q, l5_q;
  logic [QW-1:0] sq5_q  [NUM_LANES];
  logic          neg5_q [NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq5_q[l]  <= (QW'(hh_q[l]) << (2*LW)) + (QW'(hl_q[l]) << (LW+1)) + QW'(ll_q[l]);
        neg5_q[l] <= neg4_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l5_q <= l4_q;
    end
  end

  // ---------------- stage 6: sum of squares and search seed ----------------
  // Result m is the largest value with c^2 * 2^(2F+2) >= (2m-1)^2 * S.
  // Kept per lane: R = c^2 * 2^(2F+2) - t^2 * S and P = t * S, t = 2m-1 (m = 0).
  logic [SW-1:0] ssum_d;
  assign ssum_d = SW'(sq5_q[0]) + SW'(sq5_q[1]) + SW'(sq5_q[2]);

  logic                 sv_q  [NS+1];
  logic                 sl_q  [NS+1];
  logic                 sdg_q [NS+1];
  logic [SW-1:0]        ss_q  [NS+1];
  logic signed [RW-1:0] r_q   [NS+1][NUM_LANES];
  logic signed [RW-1:0] p_q   [NS+1][NUM_LANES];
  logic [NW-1:0]        m_q   [NS+1][NUM_LANES];
  logic                 sn_q  [NS+1][NUM_LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sl_q[0]  <= l5_q;
      ss_q[0]  <= ssum_d;
      sdg_q[0] <= (ssum_d == '0);
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_seed
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[0][l]  <= (RW'(sq5_q[l]) << (2*F+2)) - RW'(ssum_d);
        p_q[0][l]  <= -RW'(ssum_d);
        m_q[0][l]  <= '0;
        sn_q[0][l] <= neg5_q[l];
      end
    end
  end

  // ---------------- search stages: one result bit each, MSB first ----------------
  for (genvar j = 0; j < NS; j++) begin : g_srch
    localparam int unsigned K = NS - 1 - j;
    logic signed [RW-1:0] sx;
    assign sx = RW'(ss_q[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (adv) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sl_q[j+1]  <= sl_q[j];
        ss_q[j+1]  <= ss_q[j];
        sdg_q[j+1] <= sdg_q[j];
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic signed [RW-1:0] trial;
      // t grows by 2^(K+1): t'^2 S = t^2 S + 2^(K+2) P + 2^(2K+2) S
      assign trial = r_q[j][l] - (p_q[j][l] <<< (K+2)) - (sx << (2*K+2));
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sn_q[j+1][l] <= sn_q[j][l];
          if (!trial[RW-1]) begin
            r_q[j+1][l] <= trial;
            p_q[j+1][l] <= p_q[j][l] + (sx << (K+1));
            m_q[j+1][l] <= m_q[j][l] | (NW'(1) << K);
          end else begin
            r_q[j+1][l] <= r_q[j][l];
            p_q[j+1][l] <= p_q[j][l];
            m_q[j+1][l] <= m_q[j][l];
          end
        end
      end
    end
  end

  // ---------------- output register: clamp, sign, degenerate ----------------
  logic signed [NW-1:0] nrm_d [NUM_LANES];
  logic signed [NW-1:0] nrm_q [NUM_LANES];
  logic                 deg_q, last_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    logic [NW-1:0] nmag;
    // exact magnitude one saturates to the largest fraction
    assign nmag     = m_q[NS][l][NW-1] ? {1'b0, {F{1'b1}}} : m_q[NS][l];
    assign nrm_d[l] = sdg_q[NS] ? '0 : (sn_q[NS][l] ? -nmag : nmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sv_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nrm_q[0] <= nrm_d[0];
      nrm_q[1] <= nrm_d[1];
      nrm_q[2] <= nrm_d[2];
      deg_q    <= sdg_q[NS];
      last_q   <= sl_q[NS];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];
  assign out_o.degenerate = deg_q;
  assign out_o.last_out   = last_q;

endmodule

@@ rtl/tun_checker.sv @@
// Checker: port-level properties of the triangle unit normal block, with its bind.
`timescale 1ns / 1ps

module tun_checker import tun_pkg::*; #(
  parameter int unsigned NORMAL_FRAC_BITS = NFRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [NORMAL_FRAC_BITS:0] normal_x_i,
  input logic signed [NORMAL_FRAC_BITS:0] normal_y_i,
  input logic signed [NORMAL_FRAC_BITS:0] normal_z_i,
  input logic                          degenerate_i,
  input logic                          last_out_i
);

  localparam logic signed [NORMAL_FRAC_BITS:0] MOST_NEG = {1'b1, {NORMAL_FRAC_BITS{1'b0}}};

  // A result beat that is not taken stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(normal_x_i) && $stable(normal_y_i) && $stable(normal_z_i) &&
      $stable(degenerate_i) && $stable(last_out_i))
    else $error("output beat changed while stalled");

  // A degenerate triangle carries a zero normal
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |->
      normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0)
    else $error("degenerate beat with nonzero normal");

  // Components are clamped symmetrically
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      normal_x_i != MOST_NEG && normal_y_i != MOST_NEG && normal_z_i != MOST_NEG)
    else $error("normal component outside clamp range");

  // A held result freezes the pipe, so no new triangle is taken
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

endmodule

bind triangle_unit_normal tun_checker #(
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .normal_x_i   (out_o.normal_x),
  .normal_y_i   (out_o.normal_y),
  .normal_z_i   (out_o.normal_z),
  .degenerate_i (out_o.degenerate),
  .last_out_i   (out_o.last_out)
);

@@ tb/sv/tb_triangle_unit_normal.sv @@
// Testbench for triangle_unit_normal: streams faces, predicts the unit normal, checks each beat.
`timescale 1ns / 1ps

module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int unsigned CB       = COORD_BITS_DEF;
  localparam int unsigned NF       = NFRAC_BITS_DEF;
  localparam int          N_RANDOM = 1250;
  localparam int          LATENCY  = 7 + NF + 1;
  localparam int          LIMIT    = 250000;
  localparam int          DRAIN_AT = 700;   // sender waits for an empty pipe here
  localparam int          HOLD_AT  = 1000;  // receiver starts its long hold-off at this item
  localparam int          HOLD_LEN = 400;

  typedef struct {
    bit signed [CB-1:0] v[9];  // first xyz, second xyz, third xyz
    bit                 last;
  } face_t;

  typedef struct {
    bit signed [NF:0] n[3];
    bit               degen;
    bit               last;
  } normal_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tun_in_if  #(.COORD_BITS(CB))       in_if ();
  tun_out_if #(.NORMAL_FRAC_BITS(NF)) out_if ();

  triangle_unit_normal #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(NF)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  face_t   faces_q[$];
  normal_t normals_q[$];
  int      n_errors = 0;
  int      n_sent   = 0;
  int      cycle    = 0;

  // Exact unit normal: rounded |c_i| * 2^NF / |c| per component, ties away from zero, clamped
  function automatic normal_t face_normal(face_t f);
    longint          a[3], b[3], c[3];
    logic [127:0]    m[3], sum, lhs, rhs;
    longint unsigned lo, hi, mid, mag;
    normal_t         r;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(f.v[3+i]) - longint'(f.v[i]);
      b[i] = longint'(f.v[6+i]) - longint'(f.v[i]);
    end
    c[0] = a[1]*b[2] - a[2]*b[1];
    c[1] = a[2]*b[0] - a[0]*b[2];
    c[2] = a[0]*b[1] - a[1]*b[0];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      sum  = sum + m[i]*m[i];
    end
    r.last  = f.last;
    r.degen = (sum == 0);
    for (int i = 0; i < 3; i++) begin
      r.n[i] = '0;
      if (!r.degen) begin
        lhs = (m[i]*m[i]) << (2*NF + 2);
        lo  = 0;
        hi  = (64'd1 << NF) + 1;
        while (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          rhs = 128'(2*mid - 1);
          rhs = rhs*rhs*sum;
          if (lhs >= rhs) lo = mid;
          else            hi = mid;
        end
        mag    = (lo > (64'd1 << NF) - 1) ? (64'd1 << NF) - 1 : lo;
        r.n[i] = (c[i] < 0) ? -(NF+1)'(mag) : (NF+1)'(mag);
      end
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  function automatic face_t mk_face(int x1, int y1, int z1, int x2, int y2, int z2,
                                    int x3, int y3, int z3, bit last);
    face_t f;
    f.v = '{CB'(x1), CB'(y1), CB'(z1), CB'(x2), CB'(y2), CB'(z2), CB'(x3), CB'(y3), CB'(z3)};
    f.last = last;
    return f;
  endfunction

  // Random face: full range, small coordinates, collinear or repeated vertex
  function automatic face_t rand_face();
    face_t f;
    int    d[3];
    int    sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) f.v[i] = CB'($urandom_range(0, 65535));
    if (sel < 3) begin
      for (int i = 0; i < 9; i++) f.v[i] = CB'(int'($urandom_range(0, 16)) - 8);
    end else if (sel == 3) begin
      for (int i = 0; i < 3; i++) begin
        f.v[i]   = CB'(int'($urandom_range(0, 40000)) - 20000);
        d[i]     = int'($urandom_range(0, 1000)) - 500;
        f.v[3+i] = CB'(int'(f.v[i]) + d[i]);
        f.v[6+i] = CB'(int'(f.v[i]) - 3*d[i]);
      end
    end else if (sel == 4) begin
      for (int i = 0; i < 3; i++) f.v[6+i] = f.v[$urandom_range(0, 1)*3 + i];
    end
    f.last = $urandom_range(0, 1);
    return f;
  endfunction

  // Sender: bursts and gaps, one pause until the pipe drains
  int  burst_left = 0;
  int  gap_left   = 0;
  bit  drained    = 1'b0;

  always @(posedge clk_i) begin
    bit offer;
    if (rst_ni) begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        normals_q.push_back(face_normal(faces_q.pop_front()));
        n_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (n_sent == DRAIN_AT && !drained) begin
          if (normals_q.size() == 0) drained = 1'b1;
        end else if (faces_q.size() > 0) begin
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_if.valid <= offer;
      if (offer) begin
        in_if.first_x   <= faces_q[0].v[0];
        in_if.first_y   <= faces_q[0].v[1];
        in_if.first_z   <= faces_q[0].v[2];
        in_if.second_x  <= faces_q[0].v[3];
        in_if.second_y  <= faces_q[0].v[4];
        in_if.second_z  <= faces_q[0].v[5];
        in_if.third_x   <= faces_q[0].v[6];
        in_if.third_y   <= faces_q[0].v[7];
        in_if.third_z   <= faces_q[0].v[8];
        in_if.last_face <= faces_q[0].last;
      end
    end
  end

  // Receiver: stall pattern picked anew at random, one long hold-off
  int stall_mode = 0;
  int hold_left  = 0;
  bit held       = 1'b0;

  always @(posedge clk_i) begin
    bit rdy;
    if (cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
    if (!held && n_sent >= HOLD_AT) begin
      held      = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = $urandom_range(0, 9) != 0;
        default: rdy = (cycle % 5) != 0;
      endcase
    end
    out_if.ready <= rdy;
  end

  // Monitor: compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    normal_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (normals_q.size() == 0) begin
        $display("[%0t] unexpected output beat", $time);
        n_errors++;
      end else begin
        w = normals_q.pop_front();
        if (out_if.normal_x !== w.n[0]) report("normal_x", out_if.normal_x, w.n[0]);
        if (out_if.normal_y !== w.n[1]) report("normal_y", out_if.normal_y, w.n[1]);
        if (out_if.normal_z !== w.n[2]) report("normal_z", out_if.normal_z, w.n[2]);
        if (out_if.degenerate !== w.degen) report("degenerate", out_if.degenerate, w.degen);
        if (out_if.last_out !== w.last) report("last_out", out_if.last_out, w.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int lo16, hi16;
    lo16 = -(1 << (CB-1));
    hi16 = (1 << (CB-1)) - 1;
    in_if.valid = 1'b0;
    in_if.first_x = '0; in_if.first_y = '0; in_if.first_z = '0;
    in_if.second_x = '0; in_if.second_y = '0; in_if.second_z = '0;
    in_if.third_x = '0; in_if.third_y = '0; in_if.third_z = '0;
    in_if.last_face = 1'b0;
    out_if.ready = 1'b0;

    // Directed: zero-length cross products, axis normals that saturate, extremes
    faces_q.push_back(mk_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    faces_q.push_back(mk_face(lo16, lo16, lo16, lo16, lo16, lo16, lo16, lo16, lo16, 1));
    faces_q.push_back(mk_face(1, 2, 3, 2, 4, 6, 3, 6, 9, 0));
    faces_q.push_back(mk_face(lo16, lo16, lo16, hi16, hi16, hi16, 0, 0, 0, 1));
    faces_q.push_back(mk_face(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
    faces_q.push_back(mk_face(0, 0, 0, 0, 1, 0, 1, 0, 0, 1));
    faces_q.push_back(mk_face(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    faces_q.push_back(mk_face(0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
    faces_q.push_back(mk_face(0, 0, 0, 0, 0, 1, 1, 0, 0, 1));
    faces_q.push_back(mk_face(0, 0, 0, 1, 0, 0, 0, 0, 1, 0));
    faces_q.push_back(mk_face(lo16, lo16, 0, hi16, lo16, 0, lo16, hi16, 0, 0));
    faces_q.push_back(mk_face(hi16, hi16, hi16, lo16, hi16, lo16, hi16, lo16, lo16, 1));
    faces_q.push_back(mk_face(lo16, hi16, lo16, hi16, lo16, hi16, lo16, lo16, hi16, 0));
    faces_q.push_back(mk_face(0, 0, 0, 3, 4, 0, 0, 0, 5, 0));
    faces_q.push_back(mk_face(0, 0, 0, 1, 1, 0, 0, 1, 1, 1));
    faces_q.push_back(mk_face(-1, -1, -1, 0, -1, -1, -1, 0, -1, 0));
    faces_q.push_back(mk_face(5, 5, 5, 5, 5, 5, 9, -3, 2, 1));
    faces_q.push_back(mk_face(hi16, 0, 0, 0, hi16, 0, 0, 0, hi16, 0));
    for (int i = 0; i < N_RANDOM; i++) faces_q.push_back(rand_face());

    repeat (8) @(posedge clk_i);
    rst_ni = 1'b1;

    wait (faces_q.size() == 0 && normals_q.size() == 0);
    repeat (2 * LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && normals_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
